FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define PSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define PSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pss_pkg.sv
`timescale 1ns / 1ps

package pss_pkg;

    localparam int MAX_POOL  = 131072;
    localparam int MAX_PICKS = 256;

    localparam int TOTAL_W   = 18;
    localparam int PICKS_W   = 9;
    localparam int OFFSET_W  = 17;
    localparam int INDEX_W   = 17;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 1;

    localparam int IDX_W  = $clog2(MAX_POOL);
    localparam int CNT_W  = $clog2(MAX_POOL + 1);
    localparam int PCNT_W = $clog2(MAX_PICKS + 1);
    localparam int POS_W  = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;
    localparam int SUM_W  = ((CNT_W > OFFSET_W) ? CNT_W : OFFSET_W) + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(131072);
    localparam logic [PICKS_W-1:0] PICKS_RESET = PICKS_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOTAL_WORDS = 1'b0,
        REG_PICK_COUNT  = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P_CALC,
        ST_U_LOG,
        ST_U_FETCH,
        ST_SW_RD,
        ST_SW_WR_I,
        ST_SW_WR_J
    } t_state;

    typedef enum logic [1:0] {
        RA_POS,
        RA_I,
        RA_J
    } t_ra_sel;

    typedef enum logic [1:0] {
        WA_CLR,
        WA_I,
        WA_J
    } t_wa_sel;

    typedef struct packed {
        logic    perm_we;
        t_wa_sel wa_sel;
        t_ra_sel ra_sel;
        logic    clr_step;
        logic    take_in;
        logic    calc;
        logic    fetch;
        logic    cap_j;
        logic    out_load;
        logic    undo_cfg;
        logic    undo_dec;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic pos_nz;
        logic last;
        logic i_zero;
        logic out_free;
        logic cfg_hit;
    } t_status;

    function automatic logic [CNT_W-1:0] eff_total(input logic [TOTAL_W-1:0] t);
        logic [31:0] v;
        v = 32'(t);
        if (v == 32'd0) begin
            v = 32'd1;
        end
        if (v > 32'(MAX_POOL)) begin
            v = 32'(MAX_POOL);
        end
        return CNT_W'(v);
    endfunction

    function automatic logic [PCNT_W-1:0] eff_picks(input logic [PICKS_W-1:0] p,
                                                    input logic [CNT_W-1:0]   tot);
        logic [31:0] v;
        v = 32'(p);
        if (v == 32'd0) begin
            v = 32'd1;
        end
        if (v > 32'(MAX_PICKS)) begin
            v = 32'(MAX_PICKS);
        end
        if (v > 32'(tot)) begin
            v = 32'(tot);
        end
        return PCNT_W'(v);
    endfunction

endpackage

FILE: design/pss_ram.sv
`timescale 1ns / 1ps

module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pss_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pss_dpath
    import pss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic [OFFSET_W-1:0]   i_draw_offset,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [INDEX_W-1:0]    o_picked_index,
    output logic                  o_last_in_set,
    output logic                  o_offset_clamped
);

    logic [TOTAL_W-1:0]  r_total;
    logic [PICKS_W-1:0]  r_picks;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    r_i;
    logic [IDX_W-1:0]    r_j;
    logic [OFFSET_W-1:0] r_off;
    logic [IDX_W-1:0]    r_val_i;
    logic [IDX_W-1:0]    r_val_j;
    logic                r_clamp;
    logic [IDX_W-1:0]    r_clr;
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_index;
    logic                r_out_last;
    logic                r_out_clamp;

    logic [CNT_W-1:0]    total_eff;
    logic [PCNT_W-1:0]   picks_eff;
    logic [POS_W-1:0]    eff_i;
    logic [SUM_W-1:0]    j_raw;
    logic                clamp_c;
    logic [IDX_W-1:0]    j_calc;
    logic                last_c;

    logic [IDX_W-1:0]    perm_waddr;
    logic [IDX_W-1:0]    perm_wdata;
    logic [IDX_W-1:0]    perm_raddr;
    logic [IDX_W-1:0]    perm_rdata;
    logic [IDX_W-1:0]    log_rdata;

    assign total_eff = eff_total(r_total);
    assign picks_eff = eff_picks(r_picks, total_eff);
    assign eff_i     = (PCNT_W'(r_pos) >= picks_eff) ? '0 : r_pos;
    assign j_raw     = SUM_W'(r_i) + SUM_W'(r_off);
    assign clamp_c   = j_raw >= SUM_W'(total_eff);
    assign j_calc    = clamp_c ? IDX_W'(total_eff - CNT_W'(1)) : IDX_W'(j_raw);
    assign last_c    = (PCNT_W'(r_i) + PCNT_W'(1)) >= picks_eff;

    always_comb begin
        unique case (i_cmd.wa_sel)
            WA_CLR: begin
                perm_waddr = r_clr;
                perm_wdata = r_clr;
            end
            WA_I: begin
                perm_waddr = IDX_W'(r_i);
                perm_wdata = perm_rdata;
            end
            WA_J: begin
                perm_waddr = r_j;
                perm_wdata = r_val_i;
            end
            default: begin
                perm_waddr = r_j;
                perm_wdata = r_val_i;
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.ra_sel)
            RA_POS:  perm_raddr = IDX_W'(eff_i);
            RA_I:    perm_raddr = IDX_W'(r_i);
            RA_J:    perm_raddr = r_j;
            default: perm_raddr = r_j;
        endcase
    end

    pss_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_POOL)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (i_cmd.perm_we),
        .i_waddr (perm_waddr),
        .i_wdata (perm_wdata),
        .i_raddr (perm_raddr),
        .o_rdata (perm_rdata)
    );

    pss_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_PICKS)
    ) u_log (
        .i_clk   (i_clk),
        .i_we    (i_cmd.calc),
        .i_waddr (r_i),
        .i_wdata (j_calc),
        .i_raddr (r_i),
        .o_rdata (log_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= TOTAL_RESET;
            r_picks     <= PICKS_RESET;
            r_pos       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_TOTAL_WORDS: r_total <= TOTAL_W'(i_cfg_data);
                    REG_PICK_COUNT:  r_picks <= PICKS_W'(i_cfg_data);
                    default:         r_picks <= r_picks;
                endcase
                r_pos <= '0;
            end else if (i_cmd.out_load) begin
                r_pos <= last_c ? '0 : r_i + POS_W'(1);
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_i   <= eff_i;
            r_off <= i_draw_offset;
        end else if (i_cmd.undo_cfg) begin
            r_i <= r_pos - POS_W'(1);
        end else if (i_cmd.undo_dec) begin
            r_i <= r_i - POS_W'(1);
        end
        if (i_cmd.calc) begin
            r_val_i <= perm_rdata;
            r_j     <= j_calc;
            r_clamp <= clamp_c;
        end else if (i_cmd.fetch) begin
            r_val_i <= perm_rdata;
            r_j     <= log_rdata;
        end
        if (i_cmd.cap_j) begin
            r_val_j <= perm_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_index <= INDEX_W'(r_val_j);
            r_out_last  <= last_c;
            r_out_clamp <= r_clamp;
        end
    end

    assign o_status.clr_done = r_clr == IDX_W'(MAX_POOL - 1);
    assign o_status.pos_nz   = r_pos != '0;
    assign o_status.last     = last_c;
    assign o_status.i_zero   = r_i == '0;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.cfg_hit  = i_cfg_we;

    assign o_out_valid      = r_out_valid;
    assign o_picked_index   = r_out_index;
    assign o_last_in_set    = r_out_last;
    assign o_offset_clamped = r_out_clamp;

    `PSS_ASSERT_NXT(a_partner_in_pool, i_cmd.calc, 32'(r_j) < 32'(total_eff), "swap partner outside pool")
    `PSS_ASSERT_NXT(a_clamp_to_top, i_cmd.calc, !r_clamp || (32'(r_j) + 32'd1 == 32'(total_eff)), "clamped partner not at pool top")
    `PSS_ASSERT_IMP(a_load_free, i_cmd.out_load, !r_out_valid || i_out_ready, "result overwritten before taken")

endmodule

FILE: design/pss_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pss_ctrl
    import pss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_undo;
    logic   n_undo;
    logic   in_ready;

    assign in_ready   = (r_state == ST_IDLE) && !i_status.cfg_hit;
    assign o_in_ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_undo  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_undo  <= n_undo;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_undo  = r_undo;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                priority if (i_status.cfg_hit && i_status.pos_nz) begin
                    n_state = ST_U_LOG;
                    n_undo  = 1'b1;
                end else if (i_in_valid && in_ready) begin
                    n_state = ST_P_CALC;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_P_CALC:  n_state = ST_SW_RD;
            ST_U_LOG:   n_state = ST_U_FETCH;
            ST_U_FETCH: n_state = ST_SW_RD;
            ST_SW_RD:   n_state = ST_SW_WR_I;
            ST_SW_WR_I: n_state = ST_SW_WR_J;
            ST_SW_WR_J: begin
                priority if (r_undo) begin
                    if (i_status.i_zero) begin
                        n_state = ST_IDLE;
                        n_undo  = 1'b0;
                    end else begin
                        n_state = ST_U_LOG;
                    end
                end else if (i_status.out_free) begin
                    if (i_status.last) begin
                        n_state = ST_U_LOG;
                        n_undo  = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_SW_WR_J;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.wa_sel = WA_J;
        o_cmd.ra_sel = RA_I;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.perm_we  = 1'b1;
                o_cmd.wa_sel   = WA_CLR;
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.ra_sel   = RA_POS;
                o_cmd.take_in  = i_in_valid && in_ready;
                o_cmd.undo_cfg = i_status.cfg_hit && i_status.pos_nz;
            end
            ST_P_CALC: begin
                o_cmd.calc = 1'b1;
            end
            ST_U_LOG: begin
                o_cmd.ra_sel = RA_I;
            end
            ST_U_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            ST_SW_RD: begin
                o_cmd.ra_sel = RA_J;
            end
            ST_SW_WR_I: begin
                o_cmd.perm_we = 1'b1;
                o_cmd.wa_sel  = WA_I;
                o_cmd.cap_j   = 1'b1;
            end
            ST_SW_WR_J: begin
                o_cmd.perm_we  = 1'b1;
                o_cmd.wa_sel   = WA_J;
                o_cmd.out_load = !r_undo && i_status.out_free;
                o_cmd.undo_dec = r_undo && !i_status.i_zero;
            end
            default: begin
                o_cmd.ra_sel = RA_I;
            end
        endcase
    end

    `PSS_ASSERT_NXT(a_clear_exit, (r_state == ST_CLEAR) && i_status.clr_done, r_state == ST_IDLE, "clear pass did not end")
    `PSS_ASSERT_IMP(a_undo_mode, (r_state == ST_U_LOG) || (r_state == ST_U_FETCH), r_undo, "undo walk without undo mode")
    `PSS_ASSERT_NXT(a_pick_done, o_cmd.out_load && !i_status.last, (r_state == ST_IDLE) && !r_undo, "mid-set pick did not return to idle")

endmodule

FILE: design/partial_shuffle_sampler.sv
// Partial shuffle sampler: draws pick_count distinct indices out of 0..total_words-1.
// Request channel: i_in_valid/o_in_ready with i_draw_offset, one random offset per pick.
// Result channel: o_out_valid/i_out_ready with o_picked_index, o_last_in_set and
// o_offset_clamped, exactly one result per request.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 total_words,
// 1 pick_count) at once; a write in the middle of a set abandons the set.
// Each pick is two reads and two writes of the single-port-read permutation RAM:
// a request taken in ST_IDLE passes ST_P_CALC, ST_SW_RD, ST_SW_WR_I and ST_SW_WR_J,
// which registers the result, and no new request is taken before the pick is back
// in ST_IDLE. After the last pick of a set the logged swaps are replayed backwards,
// pick by pick, before the next request; an abandoned set replays its picks so far.
// After reset the permutation RAM is loaded with the identity, one entry per cycle,
// with o_in_ready low until that is done; config writes are taken during that time.
// A stalled receiver holds the result register; the next pick then waits in its
// final write step until the pending result is taken.
`timescale 1ns / 1ps

module partial_shuffle_sampler
    import pss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OFFSET_W-1:0]  i_draw_offset,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [INDEX_W-1:0]   o_picked_index,
    output logic                 o_last_in_set,
    output logic                 o_offset_clamped,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    pss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pss_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_draw_offset    (i_draw_offset),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_picked_index   (o_picked_index),
        .o_last_in_set    (o_last_in_set),
        .o_offset_clamped (o_offset_clamped)
    );

endmodule

FILE: verif/partial_shuffle_sampler_checker.sv
`timescale 1ns / 1ps

module partial_shuffle_sampler_checker
    import pss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [OFFSET_W-1:0]  i_draw_offset,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [INDEX_W-1:0]   i_picked_index,
    input  logic                 i_last_in_set,
    input  logic                 i_offset_clamped,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               clamped;
    } t_pick;

    logic [INDEX_W-1:0] perm_mem    [MAX_POOL];
    logic [INDEX_W-1:0] partner_log [MAX_PICKS];
    int unsigned        set_pos;
    logic [TOTAL_W-1:0] pool_reg;
    logic [PICKS_W-1:0] picks_reg;
    t_pick              queued_picks[$];
    int                 fail_count = 0;
    int                 pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic int unsigned pool_limit();
        int unsigned v;
        v = pool_reg;
        if (v == 0) begin
            v = 1;
        end
        if (v > MAX_POOL) begin
            v = MAX_POOL;
        end
        return v;
    endfunction

    function automatic int unsigned set_limit();
        int unsigned v;
        v = picks_reg;
        if (v == 0) begin
            v = 1;
        end
        if (v > MAX_PICKS) begin
            v = MAX_PICKS;
        end
        if (v > pool_limit()) begin
            v = pool_limit();
        end
        return v;
    endfunction

    task automatic exchange(input int unsigned a, input int unsigned b);
        logic [INDEX_W-1:0] t;
        t = perm_mem[a];
        perm_mem[a] = perm_mem[b];
        perm_mem[b] = t;
    endtask

    // replay logged swaps backwards to restore the identity
    task automatic rewind_set(input int unsigned n);
        for (int k = int'(n) - 1; k >= 0; k--) begin
            exchange(k, partner_log[k]);
        end
    endtask

    task automatic draw(input logic [OFFSET_W-1:0] off_in, output t_pick res);
        int unsigned pos;
        int unsigned rem;
        int unsigned off;
        int unsigned partner;
        pos = set_pos;
        if (pos >= set_limit()) begin
            pos = 0;
        end
        rem = pool_limit() - pos;
        off = off_in;
        res.clamped = 1'b0;
        if (off >= rem) begin
            off = rem - 1;
            res.clamped = 1'b1;
        end
        partner = pos + off;
        partner_log[pos] = INDEX_W'(partner);
        exchange(pos, partner);
        res.index = perm_mem[pos];
        res.last = (pos + 1 >= set_limit());
        if (res.last) begin
            rewind_set(pos + 1);
            set_pos = 0;
        end else begin
            set_pos = pos + 1;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_pick want;
        t_pick fresh;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_POOL; k++) begin
                perm_mem[k] = INDEX_W'(k);
            end
            set_pos = 0;
            pool_reg = TOTAL_W'(MAX_POOL);
            picks_reg = PICKS_W'(1);
            queued_picks.delete();
        end else begin
            if (i_cfg_we) begin
                rewind_set(set_pos);
                set_pos = 0;
                if (i_cfg_index == REG_TOTAL_WORDS) begin
                    pool_reg = i_cfg_data[TOTAL_W-1:0];
                end else begin
                    picks_reg = i_cfg_data[PICKS_W-1:0];
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (queued_picks.size() == 0) begin
                    $error("picked_index: unexpected result %0d", i_picked_index);
                    fail_count++;
                end else begin
                    want = queued_picks.pop_front();
                    if (i_picked_index !== want.index) begin
                        $error("picked_index: expected %0d, actual %0d",
                               want.index, i_picked_index);
                        fail_count++;
                    end
                    if (i_last_in_set !== want.last) begin
                        $error("last_in_set: expected %0d, actual %0d",
                               want.last, i_last_in_set);
                        fail_count++;
                    end
                    if (i_offset_clamped !== want.clamped) begin
                        $error("offset_clamped: expected %0d, actual %0d",
                               want.clamped, i_offset_clamped);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                draw(i_draw_offset, fresh);
                queued_picks.push_back(fresh);
            end
        end
        pending_count = queued_picks.size();
    end

endmodule

FILE: verif/partial_shuffle_sampler_test.sv
`timescale 1ns / 1ps

module partial_shuffle_sampler_test;
    import pss_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int UNDO_WAIT    = 5 * MAX_PICKS + 20;
    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES  = 400;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OFFSET_W-1:0] i_draw_offset;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [INDEX_W-1:0]  o_picked_index;
    logic                o_last_in_set;
    logic                o_offset_clamped;
    logic                i_cfg_we;
    t_cfg_reg            i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;

    int   fail_count;
    int   pending_count;
    int   burst_left;
    logic hold_req;

    partial_shuffle_sampler i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_draw_offset    (i_draw_offset),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_picked_index   (o_picked_index),
        .o_last_in_set    (o_last_in_set),
        .o_offset_clamped (o_offset_clamped),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    partial_shuffle_sampler_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_draw_offset    (i_draw_offset),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_picked_index   (o_picked_index),
        .i_last_in_set    (o_last_in_set),
        .i_offset_clamped (o_offset_clamped),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // result side: own stall pattern, plus one long hold-off on request
    initial begin : sink
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0: begin
                        i_out_ready = 1'b1;
                    end
                    1: begin
                        i_out_ready = $urandom_range(0, 1);
                    end
                    default: begin
                        i_out_ready = ($urandom_range(0, 5) != 0);
                    end
                endcase
            end
        end
    end

    task automatic send_pick(input logic [OFFSET_W-1:0] off);
        i_in_valid = 1'b1;
        i_draw_offset = off;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge i_clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // block idle: no result owed, and any undo walk given time to finish
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (UNDO_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int unsigned value);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic configure(input int unsigned pool_val, input int unsigned picks_val);
        settle();
        write_reg(REG_TOTAL_WORDS, pool_val);
        repeat (UNDO_WAIT) @(negedge i_clk);
        write_reg(REG_PICK_COUNT, picks_val);
    endtask

    // mostly in-range offsets for the current position, some out-of-range noise
    task automatic run_phase(input int unsigned pool_val, input int unsigned picks_val,
                             input int n_items, input logic hold_first);
        int unsigned pool_eff;
        int unsigned picks_eff;
        int unsigned rem;
        logic [OFFSET_W-1:0] off;
        pool_eff = (pool_val == 0) ? 1 : (pool_val > MAX_POOL) ? MAX_POOL : pool_val;
        picks_eff = (picks_val == 0) ? 1 : (picks_val > MAX_PICKS) ? MAX_PICKS : picks_val;
        if (picks_eff > pool_eff) begin
            picks_eff = pool_eff;
        end
        configure(pool_val, picks_val);
        if (hold_first) begin
            hold_req = 1'b1;
        end
        for (int k = 0; k < n_items; k++) begin
            rem = pool_eff - (k % picks_eff);
            if ($urandom_range(0, 99) < 85) begin
                off = OFFSET_W'($urandom_range(0, rem - 1));
            end else begin
                case ($urandom_range(0, 2))
                    0: off = OFFSET_W'($urandom);
                    1: off = (rem + 3 > MAX_POOL - 1) ? '1 :
                             OFFSET_W'(rem + $urandom_range(0, 3));
                    default: off = '1;
                endcase
            end
            send_pick(off);
        end
    endtask

    initial begin : stimulus
        int sent;
        int n;
        int unsigned pool_val;
        int unsigned picks_val;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_draw_offset = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_TOTAL_WORDS;
        i_cfg_data = '0;
        hold_req = 1'b0;
        burst_left = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: whole pool, one pick per set
        send_pick('1);
        send_pick('0);

        // full set of five, extremes and a clamp
        configure(5, 5);
        send_pick(OFFSET_W'(4));
        send_pick('1);
        send_pick(OFFSET_W'(0));
        send_pick(OFFSET_W'(1));
        send_pick(OFFSET_W'(0));

        // set abandoned by a register write
        configure(5, 5);
        send_pick(OFFSET_W'(3));
        send_pick(OFFSET_W'(2));
        configure(5, 3);
        send_pick(OFFSET_W'(0));
        send_pick(OFFSET_W'(2));
        send_pick('1);

        // zero registers act as one
        configure(0, 0);
        send_pick(OFFSET_W'(0));
        send_pick(OFFSET_W'(1));

        // pick count above pool size
        configure(3, 300);
        send_pick('1);
        send_pick('1);
        send_pick('1);

        // pool size above the maximum
        configure(200000, 2);
        send_pick('1);
        send_pick('1);

        sent = 0;
        for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
            if (ph == 0) begin
                pool_val = MAX_POOL;
                picks_val = MAX_PICKS;
                n = 260;
            end else if (ph == 1) begin
                pool_val = 1;
                picks_val = 1;
                n = 20;
            end else begin
                n = $urandom_range(20, 60);
                case ($urandom_range(0, 3))
                    0: begin
                        pool_val = $urandom_range(1, 16);
                        picks_val = $urandom_range(0, pool_val + 2);
                    end
                    1: begin
                        pool_val = $urandom_range(17, 4096);
                        picks_val = $urandom_range(1, 40);
                    end
                    2: begin
                        pool_val = $urandom_range(MAX_POOL + 1, (1 << TOTAL_W) - 1);
                        picks_val = $urandom_range(MAX_PICKS + 1, (1 << PICKS_W) - 1);
                    end
                    default: begin
                        pool_val = MAX_POOL;
                        picks_val = $urandom_range(1, MAX_PICKS);
                    end
                endcase
            end
            if (n > RANDOM_ITEMS - sent) begin
                n = RANDOM_ITEMS - sent;
            end
            run_phase(pool_val, picks_val, n, ph == 0);
            sent += n;
        end

        settle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
